[design/hfs_pkg.sv]
// ----------------------------------------------------------------------------
// hfs_pkg: shared types, codes and helpers for the handler frame stack
// Entry layout, operation and status codes, and the entry match rule.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int FrameW = 10;
  localparam int TagW   = 16;
  localparam int ModeW  = 2;
  localparam int StatW  = 2;

  // default sizes for the top level
  localparam int StackDepthDefault = 32;
  // heap size is fixed by the 10-bit frame field; addresses wrap at this size
  localparam int HeapWords         = 1024;

  // operation codes
  localparam logic [ModeW-1:0] ModePush     = 2'd0;
  localparam logic [ModeW-1:0] ModeReturn   = 2'd1;
  localparam logic [ModeW-1:0] ModeEndTry   = 2'd2;
  localparam logic [ModeW-1:0] ModeThrow    = 2'd3;

  // status codes
  localparam logic [StatW-1:0] StatOk        = 2'd0;
  localparam logic [StatW-1:0] StatOverflow  = 2'd1;
  localparam logic [StatW-1:0] StatUnderflow = 2'd2;
  localparam logic [StatW-1:0] StatUnhandled = 2'd3;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [TagW-1:0]   tag;
  } entry_t;

  // does a stored entry stop the unwind for this pop kind
  function automatic logic entry_match(input logic [ModeW-1:0] mode,
                                       input logic [TagW-1:0]  tag,
                                       input logic [TagW-1:0]  wanted);
    logic hit;
    case (mode)
      ModeReturn: hit = (tag == '0);
      ModeEndTry: hit = (tag != '0);
      default:    hit = (tag == wanted);
    endcase
    return hit;
  endfunction

  // status for a pop that ran out of entries
  function automatic logic [StatW-1:0] miss_status(input logic [ModeW-1:0] mode);
    logic [StatW-1:0] st;
    case (mode)
      ModeReturn: st = StatUnderflow;
      default:    st = StatUnhandled;
    endcase
    return st;
  endfunction

endpackage

[design/hfs_entry_ram.sv]
// ----------------------------------------------------------------------------
// hfs_entry_ram: stack entry storage
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module hfs_entry_ram #(
  parameter int Depth = hfs_pkg::StackDepthDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  hfs_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output hfs_pkg::entry_t   rdata_o
);

  hfs_pkg::entry_t mem_q [Depth];
  hfs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/handler_frame_stack.sv]
// Order: a push result is registered straight from the input beat; a pop first
// fetches the top entry, then examines one entry per cycle through the single
// read port and match compare. A pop on an empty stack is answered directly.
// Throughput: one item at a time; a new beat is taken once the sequencer is
// idle and the result register is free or draining.
// Reset: asynchronous, active low; empties the stack, entry storage is not cleared.
// ----------------------------------------------------------------------------
// handler_frame_stack: bounded call/handler frame stack
// Push frames with catch tags; unwind to call frame, any handler or a
// specific handler, one entry per cycle.
// ----------------------------------------------------------------------------
module handler_frame_stack #(
  parameter int STACK_DEPTH = hfs_pkg::StackDepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hfs_pkg::ModeW-1:0]  mode_i,
  input  logic [hfs_pkg::FrameW-1:0] frame_addr_i,
  input  logic [hfs_pkg::TagW-1:0]   catch_tag_i,
  input  logic [hfs_pkg::TagW-1:0]   wanted_exception_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [hfs_pkg::FrameW-1:0] found_frame_o,
  output logic [hfs_pkg::StatW-1:0]  status_o
);

  localparam int TopW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                       state_q, state_d;
  logic [TopW-1:0]            top_q, top_d;
  logic [TopW-1:0]            top_dec;
  logic [hfs_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [hfs_pkg::TagW-1:0]   wanted_q, wanted_d;
  logic                       out_valid_q, out_valid_d;
  logic [hfs_pkg::FrameW-1:0] found_q, found_d;
  logic [hfs_pkg::StatW-1:0]  status_q, status_d;

  logic                       we;
  logic                       re;
  hfs_pkg::entry_t            wentry;
  hfs_pkg::entry_t            rentry;
  logic                       accept;

  assign top_dec    = top_q - TopW'(1);
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign wentry.frame = hfs_pkg::FrameW'(frame_addr_i % hfs_pkg::HeapWords);
  assign wentry.tag   = catch_tag_i;

  hfs_entry_ram #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (top_q[AddrW-1:0]),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (top_dec[AddrW-1:0]),
    .rdata_o (rentry)
  );

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    mode_d      = mode_q;
    wanted_d    = wanted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    status_d    = status_q;
    we          = 1'b0;
    re          = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          mode_d   = mode_i;
          wanted_d = wanted_exception_i;
          if (mode_i == hfs_pkg::ModePush) begin
            out_valid_d = 1'b1;
            found_d     = '0;
            if (top_q == TopW'(STACK_DEPTH)) begin
              status_d = hfs_pkg::StatOverflow;
            end else begin
              we       = 1'b1;
              top_d    = top_q + TopW'(1);
              status_d = hfs_pkg::StatOk;
            end
          end else if (top_q == '0) begin
            out_valid_d = 1'b1;
            found_d     = '0;
            status_d    = hfs_pkg::miss_status(mode_i);
          end else begin
            // fetch top entry, drop it from the stack
            re      = 1'b1;
            top_d   = top_dec;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (hfs_pkg::entry_match(mode_q, rentry.tag, wanted_q)) begin
          out_valid_d = 1'b1;
          found_d     = rentry.frame;
          status_d    = hfs_pkg::StatOk;
          state_d     = StIdle;
        end else if (top_q == '0) begin
          // unwound everything: stack left empty
          out_valid_d = 1'b1;
          found_d     = '0;
          status_d    = hfs_pkg::miss_status(mode_q);
          state_d     = StIdle;
        end else begin
          re    = 1'b1;
          top_d = top_dec;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    wanted_q <= wanted_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_frame_o = found_q;
  assign status_o      = status_q;

endmodule
